>>> rtl/core/i2cmbs_pkg.sv
`default_nettype none

package i2cmbs_pkg;

   // Width of the half-period register.
   localparam int CSR_WIDTH = 12;
   localparam logic [CSR_WIDTH-1:0] HALF_PERIOD_RESET = 12'd50;

   // Command codes carried in the kind field.
   localparam logic [2:0] KIND_START     = 3'd0;
   localparam logic [2:0] KIND_STOP      = 3'd1;
   localparam logic [2:0] KIND_WRITE     = 3'd2;
   localparam logic [2:0] KIND_READ_ACK  = 3'd3;
   localparam logic [2:0] KIND_READ_NACK = 3'd4;

   // Number of data bits in one byte transfer.
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Bus sequencer slots.
   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_ST_A   = 4'd1,
      PH_ST_B   = 4'd2,
      PH_SP_A   = 4'd3,
      PH_SP_B   = 4'd4,
      PH_SP_C   = 4'd5,
      PH_WR_HI  = 4'd6,
      PH_WR_LO  = 4'd7,
      PH_WR_ACK = 4'd8,
      PH_RD_LO  = 4'd9,
      PH_RD_HI  = 4'd10,
      PH_RA_LO  = 4'd11,
      PH_RA_HI  = 4'd12
   } phase_type;

   // One request as held in the input register.
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] kind;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_type;

   // One response as held in the result register.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_bit;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/i2cmbs_if.sv
`default_nettype none

// Request channel: one sequencer step worth of command and bus input.
interface i2cmbs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] kind;
   logic [7:0] write_byte;
   logic       sda_in;

   modport source (output valid, output cmd_valid, output kind, output write_byte,
                   output sda_in, input ready);
   modport sink   (input valid, input cmd_valid, input kind, input write_byte,
                   input sda_in, output ready);
endinterface

// Response channel: bus drive levels and command status.
interface i2cmbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;
   logic       ack_bit;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output read_byte, output ack_bit, input ready);
   modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                   input done_res, input read_byte, input ack_bit, output ready);
endinterface

`default_nettype wire

>>> rtl/core/i2c_master_byte_sequencer_core.sv
// A request is held in the input register and its response in the response register.
// One request per clock while the response side accepts; the sequencer state register is
// updated once per request between the input register and the response register.
// Reset (synchronous, active high) empties both registers, sets the sequencer idle
// with SCL and SDA released, the half period to 50 and the ACK bit to one.
`default_nettype none

module i2c_master_byte_sequencer_core #(
   parameter int DIVIDER_WIDTH = 12
) (
   input  wire                                   clock,
   input  wire                                   reset,
   i2cmbs_req_if.sink                            req_chan,
   i2cmbs_rsp_if.source                          rsp_chan,
   input  wire                                   csr_we,
   input  wire [i2cmbs_pkg::CSR_WIDTH-1:0]       csr_wdata
);

   localparam int LIM_WIDTH = (DIVIDER_WIDTH > i2cmbs_pkg::CSR_WIDTH) ?
                              DIVIDER_WIDTH : i2cmbs_pkg::CSR_WIDTH;

   // Pipeline control.
   logic                 in_vld_ff, in_vld_in;
   logic                 out_vld_ff, out_vld_in;
   logic                 advance;
   logic                 req_take;

   // Payload registers.
   i2cmbs_pkg::req_type  req_ff;
   i2cmbs_pkg::rsp_type  rsp_ff, rsp_in;

   // Configuration.
   logic [i2cmbs_pkg::CSR_WIDTH-1:0] half_ff;

   // Sequencer state.
   i2cmbs_pkg::phase_type phase_ff, phase_in;
   logic [3:0]           bit_count_ff, bit_count_in;
   logic [7:0]           shift_ff, shift_in;
   logic [DIVIDER_WIDTH-1:0] div_ff, div_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_lvl_in;
   logic                 ack_ff, ack_in;
   logic [7:0]           last_read_ff, last_read_in;
   logic                 nack_ff, nack_in;

   // Slot timing.
   logic [LIM_WIDTH-1:0]     half_ext, mask_ext, sat_ext;
   logic [DIVIDER_WIDTH-1:0] limit;
   logic [DIVIDER_WIDTH:0]   div_next;
   logic                     slot_last;
   logic                     idle;
   logic                     done;
   logic [3:0]               bit_inc;
   logic                     byte_last;

   // Handshake between the two registers.
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take  = req_chan.valid && req_chan.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // Half period saturated to the divider range, with zero taken as one.
   always_comb begin
      half_ext = LIM_WIDTH'(half_ff);
      mask_ext = LIM_WIDTH'({DIVIDER_WIDTH{1'b1}});
      sat_ext  = (half_ext > mask_ext) ? mask_ext : half_ext;
      limit    = sat_ext[DIVIDER_WIDTH-1:0];
      if (limit == '0) begin
         limit = DIVIDER_WIDTH'(1);
      end
   end

   assign div_next  = {1'b0, div_ff} + (DIVIDER_WIDTH+1)'(1);
   assign slot_last = (div_next >= {1'b0, limit});
   assign idle      = (phase_ff == i2cmbs_pkg::PH_IDLE);
   assign bit_inc   = bit_count_ff + 4'd1;
   assign byte_last = (bit_inc >= i2cmbs_pkg::BITS_PER_BYTE);

   // Next sequencer slot and the completion flag.
   always_comb begin
      phase_in = phase_ff;
      done     = 1'b0;
      if (idle) begin
         if (req_ff.cmd_valid) begin
            unique case (req_ff.kind)
               i2cmbs_pkg::KIND_START:     phase_in = i2cmbs_pkg::PH_ST_A;
               i2cmbs_pkg::KIND_STOP:      phase_in = i2cmbs_pkg::PH_SP_A;
               i2cmbs_pkg::KIND_WRITE:     phase_in = i2cmbs_pkg::PH_WR_HI;
               i2cmbs_pkg::KIND_READ_ACK,
               i2cmbs_pkg::KIND_READ_NACK: phase_in = i2cmbs_pkg::PH_RD_LO;
               default:                    phase_in = phase_ff;
            endcase
         end
      end else if (slot_last) begin
         unique case (phase_ff)
            i2cmbs_pkg::PH_ST_A:   phase_in = i2cmbs_pkg::PH_ST_B;
            i2cmbs_pkg::PH_ST_B: begin
               phase_in = i2cmbs_pkg::PH_IDLE;
               done     = 1'b1;
            end
            i2cmbs_pkg::PH_SP_A:   phase_in = i2cmbs_pkg::PH_SP_B;
            i2cmbs_pkg::PH_SP_B:   phase_in = i2cmbs_pkg::PH_SP_C;
            i2cmbs_pkg::PH_SP_C: begin
               phase_in = i2cmbs_pkg::PH_IDLE;
               done     = 1'b1;
            end
            i2cmbs_pkg::PH_WR_HI:  phase_in = i2cmbs_pkg::PH_WR_LO;
            i2cmbs_pkg::PH_WR_LO:
               phase_in = byte_last ? i2cmbs_pkg::PH_WR_ACK : i2cmbs_pkg::PH_WR_HI;
            i2cmbs_pkg::PH_WR_ACK: begin
               phase_in = i2cmbs_pkg::PH_IDLE;
               done     = 1'b1;
            end
            i2cmbs_pkg::PH_RD_LO:  phase_in = i2cmbs_pkg::PH_RD_HI;
            i2cmbs_pkg::PH_RD_HI:
               phase_in = byte_last ? i2cmbs_pkg::PH_RA_LO : i2cmbs_pkg::PH_RD_LO;
            i2cmbs_pkg::PH_RA_LO:  phase_in = i2cmbs_pkg::PH_RA_HI;
            i2cmbs_pkg::PH_RA_HI: begin
               phase_in = i2cmbs_pkg::PH_IDLE;
               done     = 1'b1;
            end
            default:               phase_in = i2cmbs_pkg::PH_IDLE;
         endcase
      end
   end

   // Bus levels, divider and data registers for the slot being entered.
   always_comb begin
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      div_in       = div_ff;
      scl_in       = scl_ff;
      sda_lvl_in   = sda_ff;
      ack_in       = ack_ff;
      last_read_in = last_read_ff;
      nack_in      = nack_ff;
      if (idle) begin
         if (req_ff.cmd_valid) begin
            bit_count_in = '0;
            unique case (req_ff.kind)
               i2cmbs_pkg::KIND_START: begin
                  div_in     = '0;
                  scl_in     = 1'b1;
                  sda_lvl_in = 1'b1;
               end
               i2cmbs_pkg::KIND_STOP: begin
                  div_in     = '0;
                  sda_lvl_in = 1'b0;
               end
               i2cmbs_pkg::KIND_WRITE: begin
                  div_in     = '0;
                  shift_in   = req_ff.write_byte;
                  scl_in     = 1'b1;
                  sda_lvl_in = req_ff.write_byte[7];
               end
               i2cmbs_pkg::KIND_READ_ACK,
               i2cmbs_pkg::KIND_READ_NACK: begin
                  div_in     = '0;
                  shift_in   = '0;
                  nack_in    = (req_ff.kind == i2cmbs_pkg::KIND_READ_NACK);
                  scl_in     = 1'b0;
                  sda_lvl_in = 1'b1;
               end
               default: begin
                  div_in = div_ff;
               end
            endcase
         end
      end else if (!slot_last) begin
         div_in = div_next[DIVIDER_WIDTH-1:0];
      end else begin
         div_in = '0;
         unique case (phase_ff)
            i2cmbs_pkg::PH_ST_A: begin
               scl_in     = 1'b1;
               sda_lvl_in = 1'b0;
            end
            i2cmbs_pkg::PH_ST_B: begin
               scl_in     = 1'b0;
               sda_lvl_in = 1'b0;
            end
            i2cmbs_pkg::PH_SP_A: begin
               scl_in     = 1'b1;
               sda_lvl_in = 1'b0;
            end
            i2cmbs_pkg::PH_SP_B, i2cmbs_pkg::PH_SP_C: begin
               scl_in     = 1'b1;
               sda_lvl_in = 1'b1;
            end
            i2cmbs_pkg::PH_WR_HI: begin
               scl_in = 1'b0;
            end
            i2cmbs_pkg::PH_WR_LO: begin
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_count_in = bit_inc;
               scl_in       = 1'b1;
               sda_lvl_in   = byte_last ? 1'b1 : shift_ff[6];
            end
            i2cmbs_pkg::PH_WR_ACK: begin
               ack_in     = req_ff.sda_in;
               scl_in     = 1'b0;
               sda_lvl_in = 1'b1;
            end
            i2cmbs_pkg::PH_RD_LO: begin
               scl_in     = 1'b1;
               sda_lvl_in = 1'b1;
            end
            i2cmbs_pkg::PH_RD_HI: begin
               shift_in     = {shift_ff[6:0], req_ff.sda_in};
               bit_count_in = bit_inc;
               scl_in       = 1'b0;
               sda_lvl_in   = byte_last ? nack_ff : 1'b1;
            end
            i2cmbs_pkg::PH_RA_LO: begin
               scl_in     = 1'b1;
               sda_lvl_in = nack_ff;
            end
            i2cmbs_pkg::PH_RA_HI: begin
               last_read_in = shift_ff;
               scl_in       = 1'b0;
               sda_lvl_in   = 1'b1;
            end
            default: begin
               scl_in = scl_ff;
            end
         endcase
      end
   end

   // Response built from the state after this request.
   always_comb begin
      rsp_in.scl_out   = scl_in;
      rsp_in.sda_out   = sda_lvl_in;
      rsp_in.busy_res  = (phase_in != i2cmbs_pkg::PH_IDLE);
      rsp_in.done_res  = done;
      rsp_in.read_byte = last_read_in;
      rsp_in.ack_bit   = ack_in;
   end

   // Control and sequencer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         half_ff      <= i2cmbs_pkg::HALF_PERIOD_RESET;
         phase_ff     <= i2cmbs_pkg::PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         div_ff       <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b1;
         last_read_ff <= '0;
         nack_ff      <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_we) begin
            half_ff <= csr_wdata;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            div_ff       <= div_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_lvl_in;
            ack_ff       <= ack_in;
            last_read_ff <= last_read_in;
            nack_ff      <= nack_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.cmd_valid  <= req_chan.cmd_valid;
         req_ff.kind       <= req_chan.kind;
         req_ff.write_byte <= req_chan.write_byte;
         req_ff.sda_in     <= req_chan.sda_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Response channel drive.
   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.scl_out   = rsp_ff.scl_out;
   assign rsp_chan.sda_out   = rsp_ff.sda_out;
   assign rsp_chan.busy_res  = rsp_ff.busy_res;
   assign rsp_chan.done_res  = rsp_ff.done_res;
   assign rsp_chan.read_byte = rsp_ff.read_byte;
   assign rsp_chan.ack_bit   = rsp_ff.ack_bit;

endmodule

`default_nettype wire

>>> rtl/core/i2cmbs_checker.sv
`default_nettype none

module i2cmbs_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_scl_out,
   input wire       rsp_sda_out,
   input wire       rsp_busy_res,
   input wire       rsp_done_res,
   input wire [7:0] rsp_read_byte,
   input wire       rsp_ack_bit
);

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl_out) &&
      $stable(rsp_sda_out) && $stable(rsp_busy_res) && $stable(rsp_done_res) &&
      $stable(rsp_read_byte) && $stable(rsp_ack_bit))
      else $error("stalled response changed");

   // A completing command always leaves the sequencer idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("command done while still busy");

   // Every command ends with SCL low, or with both lines released after a stop.
   a_done_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_scl_out |-> rsp_sda_out)
      else $error("command ended with SCL high and SDA low");

endmodule

bind i2c_master_byte_sequencer_core i2cmbs_checker u_i2cmbs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_scl_out   (rsp_chan.scl_out),
   .rsp_sda_out   (rsp_chan.sda_out),
   .rsp_busy_res  (rsp_chan.busy_res),
   .rsp_done_res  (rsp_chan.done_res),
   .rsp_read_byte (rsp_chan.read_byte),
   .rsp_ack_bit   (rsp_chan.ack_bit)
);

`default_nettype wire

>>> tb/tb_i2c_master_byte_sequencer_core.sv
`timescale 1ns / 100ps

module tb_i2c_master_byte_sequencer_core;

   localparam int HALF_CLOCK = 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   // Kind codes that the sequencer must ignore.
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   // One bus command together with what the slave answers to it.
   typedef struct {
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] reply;
      logic       ack;
   } bus_op_type;

   // One directed command, optionally with the response expected when it completes.
   typedef struct {
      int         half;
      logic       cmd_valid;
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] reply;
      logic       ack;
      logic       noisy;
      logic       typed;
      i2cmbs_pkg::rsp_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [i2cmbs_pkg::CSR_WIDTH-1:0] csr_wdata = '0;

   i2cmbs_req_if req_chan();
   i2cmbs_rsp_if rsp_chan();

   i2c_master_byte_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_CLOCK) clock = ~clock;

   // Predicted sequencer state, as of every request accepted so far.
   i2cmbs_pkg::phase_type seq_phase = i2cmbs_pkg::PH_IDLE;
   logic [3:0]     seq_bits = '0;
   logic [7:0]     seq_shift = '0;
   logic [11:0]    seq_div = '0;
   logic           seq_scl = 1'b1;
   logic           seq_sda = 1'b1;
   logic           seq_ack = 1'b1;
   logic [7:0]     seq_last_read = '0;
   logic           seq_nack = 1'b0;
   logic [11:0]    half_period = i2cmbs_pkg::HALF_PERIOD_RESET;

   // What the slave drives while the current command runs.
   logic [7:0]     slave_reply = '0;
   logic           slave_ack = 1'b0;

   i2cmbs_pkg::rsp_type levels_due[$];
   bus_op_type     transfer_plan[$];
   dir_row_type    plan_rows[$];
   int             mismatch_count = 0;
   int             rsp_index = 0;
   int             idle_cycles = 0;
   int             send_gap_max = 19;
   int             recv_gap_max = 19;
   bit             hold_off_due = 1'b0;

   // Move to a new bus slot and restart the divider.
   function automatic void load_slot(i2cmbs_pkg::phase_type ph, logic scl, logic sda);
      seq_phase = ph;
      seq_scl = scl;
      seq_sda = sda;
      seq_div = '0;
   endfunction

   // End of a slot; returns one when the command completes.
   function automatic logic finish_slot(logic line);
      logic done;
      done = 1'b0;
      case (seq_phase)
         i2cmbs_pkg::PH_ST_A: load_slot(i2cmbs_pkg::PH_ST_B, 1'b1, 1'b0);
         i2cmbs_pkg::PH_ST_B: begin
            load_slot(i2cmbs_pkg::PH_IDLE, 1'b0, 1'b0);
            done = 1'b1;
         end
         i2cmbs_pkg::PH_SP_A: load_slot(i2cmbs_pkg::PH_SP_B, 1'b1, 1'b0);
         i2cmbs_pkg::PH_SP_B: load_slot(i2cmbs_pkg::PH_SP_C, 1'b1, 1'b1);
         i2cmbs_pkg::PH_SP_C: begin
            load_slot(i2cmbs_pkg::PH_IDLE, 1'b1, 1'b1);
            done = 1'b1;
         end
         i2cmbs_pkg::PH_WR_HI: load_slot(i2cmbs_pkg::PH_WR_LO, 1'b0, seq_sda);
         i2cmbs_pkg::PH_WR_LO: begin
            seq_shift = seq_shift << 1;
            seq_bits = seq_bits + 4'd1;
            if (seq_bits >= i2cmbs_pkg::BITS_PER_BYTE) begin
               load_slot(i2cmbs_pkg::PH_WR_ACK, 1'b1, 1'b1);
            end else begin
               load_slot(i2cmbs_pkg::PH_WR_HI, 1'b1, seq_shift[7]);
            end
         end
         i2cmbs_pkg::PH_WR_ACK: begin
            seq_ack = line;
            load_slot(i2cmbs_pkg::PH_IDLE, 1'b0, 1'b1);
            done = 1'b1;
         end
         i2cmbs_pkg::PH_RD_LO: load_slot(i2cmbs_pkg::PH_RD_HI, 1'b1, 1'b1);
         i2cmbs_pkg::PH_RD_HI: begin
            seq_shift = {seq_shift[6:0], line};
            seq_bits = seq_bits + 4'd1;
            if (seq_bits >= i2cmbs_pkg::BITS_PER_BYTE) begin
               load_slot(i2cmbs_pkg::PH_RA_LO, 1'b0, seq_nack);
            end else begin
               load_slot(i2cmbs_pkg::PH_RD_LO, 1'b0, 1'b1);
            end
         end
         i2cmbs_pkg::PH_RA_LO: load_slot(i2cmbs_pkg::PH_RA_HI, 1'b1, seq_nack);
         i2cmbs_pkg::PH_RA_HI: begin
            seq_last_read = seq_shift;
            load_slot(i2cmbs_pkg::PH_IDLE, 1'b0, 1'b1);
            done = 1'b1;
         end
         default: load_slot(i2cmbs_pkg::PH_IDLE, seq_scl, seq_sda);
      endcase
      return done;
   endfunction

   // Advance the predicted sequencer by one request and return its bus levels.
   function automatic i2cmbs_pkg::rsp_type step_sequencer(i2cmbs_pkg::req_type r);
      i2cmbs_pkg::rsp_type levels;
      logic [11:0] span;
      logic       done;
      done = 1'b0;
      if (seq_phase == i2cmbs_pkg::PH_IDLE) begin
         if (r.cmd_valid) begin
            seq_bits = '0;
            case (r.kind)
               i2cmbs_pkg::KIND_START: load_slot(i2cmbs_pkg::PH_ST_A, 1'b1, 1'b1);
               i2cmbs_pkg::KIND_STOP: load_slot(i2cmbs_pkg::PH_SP_A, seq_scl, 1'b0);
               i2cmbs_pkg::KIND_WRITE: begin
                  seq_shift = r.write_byte;
                  load_slot(i2cmbs_pkg::PH_WR_HI, 1'b1, r.write_byte[7]);
               end
               i2cmbs_pkg::KIND_READ_ACK, i2cmbs_pkg::KIND_READ_NACK: begin
                  seq_shift = '0;
                  seq_nack = (r.kind == i2cmbs_pkg::KIND_READ_NACK);
                  load_slot(i2cmbs_pkg::PH_RD_LO, 1'b0, 1'b1);
               end
               default: ;
            endcase
         end
      end else begin
         // A zero half period is taken as one.
         span = (half_period == '0) ? 12'd1 : half_period;
         if (int'(seq_div) + 1 >= int'(span)) begin
            done = finish_slot(r.sda_in);
         end else begin
            seq_div = seq_div + 12'd1;
         end
      end
      levels.scl_out = seq_scl;
      levels.sda_out = seq_sda;
      levels.busy_res = (seq_phase != i2cmbs_pkg::PH_IDLE);
      levels.done_res = done;
      levels.read_byte = seq_last_read;
      levels.ack_bit = seq_ack;
      return levels;
   endfunction

   // SDA as the slave drives it in the current slot; random where nobody listens.
   function automatic logic line_level();
      if (seq_phase == i2cmbs_pkg::PH_RD_HI) begin
         return slave_reply[7 - seq_bits];
      end else if (seq_phase == i2cmbs_pkg::PH_WR_ACK) begin
         return slave_ack;
      end
      return 1'($urandom);
   endfunction

   function automatic bus_op_type random_op(logic [2:0] kind);
      bus_op_type op;
      op.kind = kind;
      op.data = 8'($urandom);
      op.reply = 8'($urandom);
      op.ack = ($urandom_range(0, 3) == 0);
      return op;
   endfunction

   // A transfer: start, address, a few data bytes, maybe a final read, mostly a stop.
   function automatic void plan_transfer();
      int count;
      count = $urandom_range(0, 3);
      transfer_plan.push_back(random_op(i2cmbs_pkg::KIND_START));
      transfer_plan.push_back(random_op(i2cmbs_pkg::KIND_WRITE));
      repeat (count) begin
         transfer_plan.push_back(random_op($urandom_range(0, 1) ?
                                           i2cmbs_pkg::KIND_WRITE :
                                           i2cmbs_pkg::KIND_READ_ACK));
      end
      if ($urandom_range(0, 1) == 1) begin
         transfer_plan.push_back(random_op(i2cmbs_pkg::KIND_READ_NACK));
      end
      if ($urandom_range(0, 9) != 0) begin
         transfer_plan.push_back(random_op(i2cmbs_pkg::KIND_STOP));
      end
   endfunction

   // Next random request: mostly well-formed transfers when idle, ignored commands while busy.
   function automatic i2cmbs_pkg::req_type next_request();
      i2cmbs_pkg::req_type r;
      bus_op_type op;
      r.cmd_valid = 1'b0;
      r.kind = 3'($urandom);
      r.write_byte = 8'($urandom);
      r.sda_in = line_level();
      if (seq_phase == i2cmbs_pkg::PH_IDLE) begin
         if ($urandom_range(0, 5) == 0) begin
            r.cmd_valid = 1'($urandom);
         end else begin
            if (transfer_plan.size() == 0) begin
               plan_transfer();
            end
            op = transfer_plan.pop_front();
            r.cmd_valid = 1'b1;
            r.kind = op.kind;
            r.write_byte = op.data;
            slave_reply = op.reply;
            slave_ack = op.ack;
         end
      end else begin
         r.cmd_valid = ($urandom_range(0, 9) == 0);
      end
      return r;
   endfunction

   function automatic void add_row(int half, logic cmd_valid, logic [2:0] kind,
                                   logic [7:0] data, logic [7:0] reply, logic ack,
                                   logic noisy, logic typed, i2cmbs_pkg::rsp_type want);
      dir_row_type row;
      row.half = half;
      row.cmd_valid = cmd_valid;
      row.kind = kind;
      row.data = data;
      row.reply = reply;
      row.ack = ack;
      row.noisy = noisy;
      row.typed = typed;
      row.want = want;
      plan_rows.push_back(row);
   endfunction

   // Offer one request after a random gap and predict its response on acceptance.
   // A typed response replaces the prediction for the request that leaves the bus idle.
   task automatic send_request(input i2cmbs_pkg::req_type r, input logic typed,
                               input i2cmbs_pkg::rsp_type want);
      int      gap;
      i2cmbs_pkg::rsp_type predicted;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd_valid <= r.cmd_valid;
      req_chan.kind <= r.kind;
      req_chan.write_byte <= r.write_byte;
      req_chan.sda_in <= r.sda_in;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = step_sequencer(r);
      levels_due.push_back((typed && seq_phase == i2cmbs_pkg::PH_IDLE) ? want : predicted);
   endtask

   // Keep the sequencer stepping until the predicted command is over.
   task automatic finish_command();
      int saved_send;
      int saved_recv;
      saved_send = send_gap_max;
      saved_recv = recv_gap_max;
      send_gap_max = 0;
      recv_gap_max = 0;
      while (seq_phase != i2cmbs_pkg::PH_IDLE) begin
         send_request(next_request(), 1'b0, '0);
      end
      send_gap_max = saved_send;
      recv_gap_max = saved_recv;
   endtask

   // Stop offering requests and wait until every response is in, plus some margin.
   task automatic quiesce(input int linger);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (linger) @(posedge clock);
   endtask

   task automatic load_half_period(input logic [11:0] value);
      quiesce(4);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      half_period = value;
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("%0t: response %0d %s got %0h expected %0h",
               $time, rsp_index, what, got, want);
   endtask

   // Response side: random stalls, one long hold-off on demand, and the field checks.
   initial begin
      int      hold;
      i2cmbs_pkg::rsp_type want;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = $urandom_range(0, recv_gap_max);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (levels_due.size() == 0) begin
            report_mismatch("unexpected response", 8'd1, 8'd0);
         end else begin
            want = levels_due.pop_front();
            if (rsp_chan.scl_out !== want.scl_out)
               report_mismatch("scl_out", 8'(rsp_chan.scl_out), 8'(want.scl_out));
            if (rsp_chan.sda_out !== want.sda_out)
               report_mismatch("sda_out", 8'(rsp_chan.sda_out), 8'(want.sda_out));
            if (rsp_chan.busy_res !== want.busy_res)
               report_mismatch("busy_res", 8'(rsp_chan.busy_res), 8'(want.busy_res));
            if (rsp_chan.done_res !== want.done_res)
               report_mismatch("done_res", 8'(rsp_chan.done_res), 8'(want.done_res));
            if (rsp_chan.read_byte !== want.read_byte)
               report_mismatch("read_byte", rsp_chan.read_byte, want.read_byte);
            if (rsp_chan.ack_bit !== want.ack_bit)
               report_mismatch("ack_bit", 8'(rsp_chan.ack_bit), 8'(want.ack_bit));
         end
         rsp_index++;
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus: reset, directed commands, then random phases at several half periods.
   initial begin
      i2cmbs_pkg::req_type r;
      int unsigned phase_half[9];
      int          phase_items;
      req_chan.valid = 1'b0;
      req_chan.cmd_valid = 1'b0;
      req_chan.kind = i2cmbs_pkg::KIND_START;
      req_chan.write_byte = '0;
      req_chan.sda_in = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset levels and ignored kinds at the reset half period.
      add_row(-1, 1'b0, i2cmbs_pkg::KIND_START, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1});
      add_row(-1, 1'b1, KIND_SPARE_LO, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1});
      add_row(-1, 1'b1, KIND_SPARE_HI, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1});
      // Half period of one: start, write and both reads with extreme bytes.
      add_row(1, 1'b1, i2cmbs_pkg::KIND_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1});
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_WRITE, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0});
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_WRITE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1,
              '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1});
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0});
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_READ_ACK, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0});
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_READ_NACK, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0});
      // Commands offered while busy must be ignored.
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_READ_ACK, 8'h00, 8'h5A, 1'b0, 1'b1, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 1'b0, 1'b1, 8'h5A, 1'b0});
      // A stop with SCL already released keeps SCL high.
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      // Zero half period behaves as a half period of one.
      add_row(0, 1'b1, i2cmbs_pkg::KIND_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_WRITE, 8'h81, 8'h00, 1'b1, 1'b1, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_READ_NACK, 8'h00, 8'h3C, 1'b0, 1'b0, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(2, 1'b1, i2cmbs_pkg::KIND_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_WRITE, 8'h7E, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_READ_ACK, 8'h00, 8'hC3, 1'b0, 1'b1, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      // Repeated start without a stop in between.
      add_row(3, 1'b1, i2cmbs_pkg::KIND_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_START, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(-1, 1'b1, i2cmbs_pkg::KIND_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0);

      foreach (plan_rows[i]) begin
         if (plan_rows[i].half >= 0) begin
            load_half_period(12'(plan_rows[i].half));
         end
         slave_reply = plan_rows[i].reply;
         slave_ack = plan_rows[i].ack;
         r.cmd_valid = plan_rows[i].cmd_valid;
         r.kind = plan_rows[i].kind;
         r.write_byte = plan_rows[i].data;
         r.sda_in = 1'b1;
         send_request(r, plan_rows[i].typed, plan_rows[i].want);
         while (seq_phase != i2cmbs_pkg::PH_IDLE) begin
            r.cmd_valid = plan_rows[i].noisy && ($urandom_range(0, 1) == 1);
            r.kind = 3'($urandom);
            r.write_byte = 8'($urandom);
            r.sda_in = line_level();
            send_request(r, plan_rows[i].typed, plan_rows[i].want);
         end
      end

      // Random phases; the widest half period only gets a short run, and the
      // command it leaves open carries on under the next, shorter half period.
      phase_half = '{1, 0, 2, 3, 1, 4095, 6, 1, $urandom_range(1, 12)};
      for (int p = 0; p < 9; p++) begin
         load_half_period(12'(phase_half[p]));
         send_gap_max = 19;
         recv_gap_max = 19;
         if (p == 4) begin
            // Sender keeps offering while the receiver holds off for a long stretch.
            send_gap_max = 0;
            hold_off_due = 1'b1;
         end else if (p == 7) begin
            send_gap_max = 0;
            recv_gap_max = 0;
         end
         phase_items = (phase_half[p] == 4095) ? 40 : 180;
         repeat (phase_items) begin
            send_request(next_request(), 1'b0, '0);
         end
         if (phase_half[p] != 4095) begin
            finish_command();
         end
      end

      quiesce(12);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/i2cmbs_pkg.sv
rtl/core/i2cmbs_if.sv
rtl/core/i2c_master_byte_sequencer_core.sv
rtl/core/i2cmbs_checker.sv
tb/tb_i2c_master_byte_sequencer_core.sv
